@@ src/bsrl_pkg.sv @@
`timescale 1ns / 1ps

package bsrl_pkg;

    localparam int OPCODE_W     = 1;
    localparam int TARGET_W     = 2;
    localparam int INDEX_OUT_W  = 2;
    localparam int COUNT_OUT_W  = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 3;
    localparam int BCOUNT_W     = 3;

    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 3'd4;

    localparam logic [OPCODE_W-1:0] OP_SELECT = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_STATUS = 1'b1;

    localparam logic POLICY_RR = 1'b0;
    localparam logic POLICY_LC = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKEND_COUNT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_READ,
        S_BUMP
    } t_state;

endpackage

@@ src/backend_selector_rr_least_count.sv @@
`timescale 1ns / 1ps

// A status beat gives its result in the cycle after acceptance. A request runs
// a scan that visits one backend entry per cycle, up to N entries, N being the backend
// count clamped to 1..MAX_TARGETS; least-count mode adds a drain, then a found entry is
// read and bumped. One item at a time; busy is high until the result strobe.
// A status beat can follow every cycle; a request only once busy is low again.
// The receiver cannot stall. Synchronous active-low reset: all backends up, counters zero.
module backend_selector_rr_least_count
    import bsrl_pkg::*;
#(
    parameter int MAX_TARGETS  = 4,
    parameter int COUNTER_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [OPCODE_W-1:0]    i_opcode,
    input  logic [TARGET_W-1:0]    i_target_index,
    input  logic                   i_is_up,
    output logic                   o_valid,
    output logic                   o_found,
    output logic [INDEX_OUT_W-1:0] o_chosen_index,
    output logic [COUNT_OUT_W-1:0] o_chosen_count,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CNT_W = $clog2(MAX_TARGETS + 1);
    localparam int TGT_W = (CNT_W > TARGET_W) ? CNT_W : TARGET_W;

    t_state                  r_state, n_state;
    logic                    r_mode;
    logic [BCOUNT_W-1:0]     r_bcount;
    logic [MAX_TARGETS-1:0]  r_up;
    logic [IDX_W-1:0]        r_ptr;
    logic [CNT_W-1:0]        r_n;
    logic [IDX_W-1:0]        r_idx;
    logic [CNT_W-1:0]        r_steps;
    logic                    r_found;
    logic [IDX_W-1:0]        r_best_idx;
    logic [COUNTER_BITS-1:0] r_best_val;
    logic                    r_rd_v;
    logic                    r_rd_up;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_o_valid;
    logic                    r_o_found;
    logic [INDEX_OUT_W-1:0]  r_o_index;
    logic [COUNT_OUT_W-1:0]  r_o_count;

    logic                    w_accept;
    logic [CNT_W-1:0]        w_n;
    logic [CNT_W-1:0]        w_idx_p1;
    logic [IDX_W-1:0]        w_idx_next;
    logic                    w_last;
    logic [IDX_W-1:0]        w_ptr_eff;
    logic [COUNTER_BITS-1:0] w_rd_data;
    logic [COUNTER_BITS-1:0] w_inc;
    logic                    w_upd;
    logic                    w_found_nx;
    logic                    w_rd_en;
    logic [IDX_W-1:0]        w_rd_addr;
    logic                    w_wr_en;

    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_bcount == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_bcount) > 32'(MAX_TARGETS)) begin
            w_n = CNT_W'(MAX_TARGETS);
        end else begin
            w_n = CNT_W'(r_bcount);
        end
    end

    assign w_idx_p1   = CNT_W'(r_idx) + CNT_W'(1);
    assign w_idx_next = (w_idx_p1 >= r_n) ? '0 : IDX_W'(w_idx_p1);
    assign w_last     = (CNT_W'(r_steps + CNT_W'(1)) == r_n);
    assign w_ptr_eff  = (CNT_W'(r_ptr) >= w_n) ? '0 : r_ptr;

    assign w_inc      = (&w_rd_data) ? w_rd_data : w_rd_data + COUNTER_BITS'(1);
    assign w_upd      = r_rd_v && r_rd_up && (!r_found || (w_rd_data < r_best_val));
    assign w_found_nx = r_found || w_upd;

    bsrl_cnt_store #(
        .DEPTH (MAX_TARGETS),
        .WIDTH (COUNTER_BITS),
        .AW    (IDX_W)
    ) u_cnt_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_best_idx),
        .i_wr_data (w_inc)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_opcode == OP_SELECT)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_mode == POLICY_RR) begin
                    if (r_up[r_idx]) begin
                        n_state = S_READ;
                    end else if (w_last) begin
                        n_state = S_IDLE;
                    end
                end else if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = w_found_nx ? S_READ : S_IDLE;
            end
            S_READ:  n_state = S_BUMP;
            S_BUMP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx;
        w_wr_en   = 1'b0;
        case (r_state)
            S_SCAN:  w_rd_en = (r_mode == POLICY_LC);
            S_READ: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_best_idx;
            end
            S_BUMP:  w_wr_en = 1'b1;
            default: w_rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= POLICY_RR;
            r_bcount   <= BCOUNT_RESET;
            r_up       <= '1;
            r_ptr      <= '0;
            r_n        <= '0;
            r_idx      <= '0;
            r_steps    <= '0;
            r_found    <= 1'b0;
            r_best_idx <= '0;
            r_best_val <= '0;
            r_rd_v     <= 1'b0;
            r_rd_up    <= 1'b0;
            r_rd_idx   <= '0;
            r_o_valid  <= 1'b0;
            r_o_found  <= 1'b0;
            r_o_index  <= '0;
            r_o_count  <= '0;
        end else begin
            r_o_valid <= 1'b0;
            r_rd_v    <= (r_state == S_SCAN) && (r_mode == POLICY_LC);
            r_rd_up   <= r_up[r_idx];
            r_rd_idx  <= r_idx;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_POLICY_MODE:   r_mode   <= i_cfg_data[0];
                    CFG_BACKEND_COUNT: r_bcount <= BCOUNT_W'(i_cfg_data);
                    default:           r_mode   <= r_mode;
                endcase
            end

            if (w_upd) begin
                r_found    <= 1'b1;
                r_best_idx <= r_rd_idx;
                r_best_val <= w_rd_data;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_opcode == OP_STATUS) begin
                            if (TGT_W'(i_target_index) < TGT_W'(w_n)) begin
                                r_up[IDX_W'(i_target_index)] <= i_is_up;
                            end
                            r_o_valid <= 1'b1;
                            r_o_found <= 1'b0;
                            r_o_index <= '0;
                            r_o_count <= '0;
                        end else begin
                            r_n     <= w_n;
                            r_steps <= '0;
                            r_found <= 1'b0;
                            if (r_mode == POLICY_RR) begin
                                r_ptr <= w_ptr_eff;
                                r_idx <= w_ptr_eff;
                            end else begin
                                r_idx <= '0;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    r_steps <= CNT_W'(r_steps + CNT_W'(1));
                    if (r_mode == POLICY_RR) begin
                        if (r_up[r_idx]) begin
                            r_best_idx <= r_idx;
                            r_ptr      <= w_idx_next;
                        end else begin
                            r_idx <= w_idx_next;
                            if (w_last) begin
                                r_o_valid <= 1'b1;
                                r_o_found <= 1'b0;
                                r_o_index <= '0;
                                r_o_count <= '0;
                            end
                        end
                    end else begin
                        r_idx <= w_idx_next;
                    end
                end
                S_DRAIN: begin
                    if (!w_found_nx) begin
                        r_o_valid <= 1'b1;
                        r_o_found <= 1'b0;
                        r_o_index <= '0;
                        r_o_count <= '0;
                    end
                end
                S_BUMP: begin
                    r_o_valid <= 1'b1;
                    r_o_found <= 1'b1;
                    r_o_index <= INDEX_OUT_W'(r_best_idx);
                    r_o_count <= COUNT_OUT_W'(w_inc);
                end
                default: r_o_valid <= 1'b0;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_found        = r_o_found;
    assign o_chosen_index = r_o_index;
    assign o_chosen_count = r_o_count;

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_chosen_index == '0) && (o_chosen_count == '0))
        else $error("result beat without a backend carries nonzero fields");

    a_status_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_STATUS)) |=> (o_valid && !o_found && !busy))
        else $error("status beat did not produce its result on the next cycle");

    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == OP_SELECT)) |=> (busy && !o_valid))
        else $error("request beat did not start the scan");

    a_bump_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUMP) |=> (o_valid && o_found && !busy))
        else $error("counter update did not deliver a found result");

endmodule

@@ src/bsrl_cnt_store.sv @@
`timescale 1ns / 1ps

module bsrl_cnt_store
    import bsrl_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int WIDTH = 32,
    parameter int AW    = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    // Entries never written read as zero through the valid bits.
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_vld  <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
